### rtl/baro_temp_pressure_compensation_assert.svh
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_assert.svh
// assertion macros for the compensation block, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, ignored during reset
`define BTPC_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, ignored during reset
`define BTPC_ASSERT_NXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define BTPC_ASSERT_IMP(label, clk, rst, a, b, msg)
`define BTPC_ASSERT_NXT(label, clk, rst, a, b, msg)
`endif

`endif

### rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// shared types, register indexes and the divider step
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam logic [1:0] REG_TEMP_COEFFS       = 2'd0;
  localparam logic [1:0] REG_PRESS_COEFFS_LOW  = 2'd1;
  localparam logic [1:0] REG_PRESS_COEFFS_HIGH = 2'd2;
  localparam logic [1:0] REG_PRESS_COEFF_NINE  = 2'd3;

  localparam int DIV_BITS = 64;

  // values that ride along the divider
  typedef struct packed {
    logic [31:0] temp;
    logic        dz;
    logic        neg;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
  } div_state_t;

  // one restoring step: shift in the next dividend bit, trial subtract
  function automatic div_state_t div_step(input logic [63:0] rem, input logic [63:0] quo,
                                          input logic [63:0] den);
    logic [63:0] sh;
    logic [64:0] diff;
    div_state_t  r;
    sh   = {rem[62:0], quo[63]};
    diff = {1'b0, sh} - {1'b0, den};
    if (!diff[64]) begin
      r.rem = diff[63:0];
      r.quo = {quo[62:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {quo[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// pipelined unsigned 64-bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module btpc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_num,
  input  logic [63:0]         in_den,
  input  btpc_pkg::side_t     in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_quo,
  output btpc_pkg::side_t     out_side
);

  localparam int DEPTH = btpc_pkg::DIV_BITS;

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] en;
  logic [63:0]      rem  [DEPTH];
  logic [63:0]      quo  [DEPTH];
  logic [63:0]      den  [DEPTH];
  btpc_pkg::side_t  side [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic            src_vld;
    logic [63:0]     src_rem;
    logic [63:0]     src_quo;
    logic [63:0]     src_den;
    btpc_pkg::side_t src_side;
    btpc_pkg::div_state_t nxt;

    // a stage moves when the output drains or when it or any later stage holds a bubble
    assign en[k] = out_ready | ~(&vld[DEPTH-1:k]);

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_quo  = in_num;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_quo  = quo[k-1];
      assign src_den  = den[k-1];
      assign src_side = side[k-1];
    end

    assign nxt = btpc_pkg::div_step(src_rem, src_quo, src_den);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && src_vld) begin
        rem[k]  <= nxt.rem;
        quo[k]  <= nxt.quo;
        den[k]  <= src_den;
        side[k] <= src_side;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[DEPTH-1];
  assign out_quo   = quo[DEPTH-1];
  assign out_side  = side[DEPTH-1];

endmodule

### rtl/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// integer temperature and pressure compensation of raw barometer readings
// ----------------------------------------------------------------------------
// One raw temperature / raw pressure pair enters per transfer and one result
// leaves per transfer, in order. The datapath is a fixed pipeline of 80
// register stages: 11 front stages (temperature path, fine temperature,
// pressure coefficients, dividend and divisor), 64 stages of a restoring
// divider that resolves one quotient bit per stage, and 5 back stages
// (pressure correction terms and the output register). Throughput is one
// item per cycle while the output does not stall. Any stage holding a bubble
// lets the stages before it move on, so the input keeps taking items while a
// result waits, until every stage is full. The user must write calibration
// words through the cfg port only while the block is idle; the block does not
// enforce this. The stages that need them read them directly. A zero divisor
// gives pressure 0 with divisor_zero set; the temperature is still reported.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"

module baro_temp_pressure_compensation (
  input  logic               clk,
  input  logic               rst,
  // calibration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // sample input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_pa,
  output logic               divisor_zero
);

  localparam int FRONT = 11;
  localparam int BACK  = 5;

  // calibration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        btpc_pkg::REG_TEMP_COEFFS:       temp_coeffs       <= cfg_data[47:0];
        btpc_pkg::REG_PRESS_COEFFS_LOW:  press_coeffs_low  <= cfg_data;
        btpc_pkg::REG_PRESS_COEFFS_HIGH: press_coeffs_high <= cfg_data;
        btpc_pkg::REG_PRESS_COEFF_NINE:  press_coeff_nine  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // unpacked calibration words
  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [63:0] p4_64, p7_64;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = press_coeffs_low[15:0];
  assign p2 = $signed(press_coeffs_low[31:16]);
  assign p3 = $signed(press_coeffs_low[47:32]);
  assign p4 = $signed(press_coeffs_low[63:48]);
  assign p5 = $signed(press_coeffs_high[15:0]);
  assign p6 = $signed(press_coeffs_high[31:16]);
  assign p7 = $signed(press_coeffs_high[47:32]);
  assign p8 = $signed(press_coeffs_high[63:48]);
  assign p9 = $signed(press_coeff_nine);
  assign p4_64 = $signed({{48{p4[15]}}, p4});
  assign p7_64 = $signed({{48{p7[15]}}, p7});

  // pipeline flow control
  logic [FRONT-1:0] fv;
  logic [FRONT-1:0] fen;
  logic [BACK-1:0]  bv;
  logic [BACK-1:0]  ben;
  logic             div_in_ready;
  logic             div_out_valid;

  for (genvar k = 0; k < FRONT; k++) begin : g_fen
    assign fen[k] = div_in_ready | ~(&fv[FRONT-1:k]);
  end
  for (genvar k = 0; k < BACK; k++) begin : g_ben
    assign ben[k] = out_ready | ~(&bv[BACK-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      bv <= '0;
    end else begin
      if (fen[0]) fv[0] <= in_valid;
      for (int k = 1; k < FRONT; k++) begin
        if (fen[k]) fv[k] <= fv[k-1];
      end
      if (ben[0]) bv[0] <= div_out_valid;
      for (int k = 1; k < BACK; k++) begin
        if (ben[k]) bv[k] <= bv[k-1];
      end
    end
  end

  assign in_ready = fen[0];

  // ---------------- front: temperature path ----------------
  logic [31:0]        s0_a, s0_b;
  logic [19:0]        s0_adcp;
  logic signed [31:0] s1_m1;
  logic [31:0]        s1_bb;
  logic [19:0]        s1_adcp;
  logic signed [31:0] s2_tv1, s2_q;
  logic [19:0]        s2_adcp;
  logic signed [31:0] s3_fine;
  logic [19:0]        s3_adcp;
  logic signed [31:0] s4_temp;
  logic signed [32:0] s4_v1;
  logic [19:0]        s4_adcp;

  logic signed [31:0] tsum;
  assign tsum = s3_fine * 32'sd5 + 32'sd128;

  always_ff @(posedge clk) begin
    // raw offsets from t1
    if (fen[0] && in_valid) begin
      s0_a    <= {15'd0, raw_temperature[19:3]} - {15'd0, t1, 1'b0};
      s0_b    <= {16'd0, raw_temperature[19:4]} - {16'd0, t1};
      s0_adcp <= raw_pressure;
    end
    if (fen[1] && fv[0]) begin
      s1_m1   <= $signed(s0_a) * t2;
      s1_bb   <= s0_b * s0_b;
      s1_adcp <= s0_adcp;
    end
    if (fen[2] && fv[1]) begin
      s2_tv1  <= s1_m1 >>> 11;
      s2_q    <= ($signed(s1_bb) >>> 12) * t3;
      s2_adcp <= s1_adcp;
    end
    // fine temperature
    if (fen[3] && fv[2]) begin
      s3_fine <= s2_tv1 + (s2_q >>> 14);
      s3_adcp <= s2_adcp;
    end
    if (fen[4] && fv[3]) begin
      s4_temp <= tsum >>> 8;
      s4_v1   <= $signed({s3_fine[31], s3_fine}) - 33'sd128000;
      s4_adcp <= s3_adcp;
    end
  end

  // ---------------- front: pressure coefficients ----------------
  logic signed [63:0] s5_v1sq, s5_v1p5, s5_v1p2;
  logic signed [31:0] s5_temp;
  logic [19:0]        s5_adcp;
  logic signed [63:0] s6_x6, s6_x3, s6_v1p5, s6_v1p2;
  logic signed [31:0] s6_temp;
  logic [19:0]        s6_adcp;
  logic signed [63:0] s7_v2;
  logic [63:0]        s7_u;
  logic signed [31:0] s7_temp;
  logic [19:0]        s7_adcp;
  logic signed [63:0] s8_den;
  logic [63:0]        s8_num0;
  logic signed [31:0] s8_temp;
  logic [63:0]        s9_num, s9_den;
  logic signed [31:0] s9_temp;
  logic [63:0]        s10_anum, s10_aden;
  btpc_pkg::side_t    s10_side;

  logic [63:0] u_p1;
  logic [20:0] pp;
  assign u_p1 = s7_u * {48'd0, p1};
  assign pp   = 21'd1048576 - {1'b0, s7_adcp};

  always_ff @(posedge clk) begin
    if (fen[5] && fv[4]) begin
      s5_v1sq <= s4_v1 * s4_v1;
      s5_v1p5 <= s4_v1 * p5;
      s5_v1p2 <= s4_v1 * p2;
      s5_temp <= s4_temp;
      s5_adcp <= s4_adcp;
    end
    if (fen[6] && fv[5]) begin
      s6_x6   <= s5_v1sq * p6;
      s6_x3   <= s5_v1sq * p3;
      s6_v1p5 <= s5_v1p5;
      s6_v1p2 <= s5_v1p2;
      s6_temp <= s5_temp;
      s6_adcp <= s5_adcp;
    end
    if (fen[7] && fv[6]) begin
      s7_v2   <= s6_x6 + (s6_v1p5 <<< 17) + (p4_64 <<< 35);
      s7_u    <= 64'(s6_x3 >>> 8) + 64'(s6_v1p2 <<< 12) + 64'h0000_8000_0000_0000;
      s7_temp <= s6_temp;
      s7_adcp <= s6_adcp;
    end
    // divisor and raw dividend
    if (fen[8] && fv[7]) begin
      s8_den  <= $signed(u_p1) >>> 33;
      s8_num0 <= ({43'd0, pp} << 31) - 64'(s7_v2);
      s8_temp <= s7_temp;
    end
    if (fen[9] && fv[8]) begin
      s9_num  <= s8_num0 * 64'd3125;
      s9_den  <= 64'(s8_den);
      s9_temp <= s8_temp;
    end
    // magnitudes and quotient sign for the unsigned divider
    if (fen[10] && fv[9]) begin
      s10_anum      <= s9_num[63] ? (64'd0 - s9_num) : s9_num;
      s10_aden      <= s9_den[63] ? (64'd0 - s9_den) : s9_den;
      s10_side.temp <= s9_temp;
      s10_side.dz   <= (s9_den == 64'd0);
      s10_side.neg  <= s9_num[63] ^ s9_den[63];
    end
  end

  // ---------------- divider ----------------
  logic [63:0]     div_quo;
  btpc_pkg::side_t div_side;

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv[FRONT-1]),
    .in_ready  (div_in_ready),
    .in_num    (s10_anum),
    .in_den    (s10_aden),
    .in_side   (s10_side),
    .out_valid (div_out_valid),
    .out_ready (ben[0]),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------- back: pressure correction ----------------
  logic signed [63:0] b0_p;
  logic [31:0]        b0_temp;
  logic               b0_dz;
  logic signed [63:0] b1_p, b1_m, b1_w2r;
  logic [31:0]        b1_temp;
  logic               b1_dz;
  logic signed [63:0] b2_p, b2_w2;
  logic [63:0]        b2_lo;
  logic [31:0]        b2_c1, b2_c2;
  logic [31:0]        b2_temp;
  logic               b2_dz;
  logic signed [63:0] b3_p, b3_w1, b3_w2;
  logic [31:0]        b3_temp;
  logic               b3_dz;

  logic signed [63:0] b0_ps, b1_ps, b3_s;
  logic [63:0]        b2_sum;
  assign b0_ps  = b0_p >>> 13;
  assign b1_ps  = b1_p >>> 13;
  assign b2_sum = b2_lo + {b2_c1 + b2_c2, 32'd0};
  assign b3_s   = ((b3_p + b3_w1 + b3_w2) >>> 8) + (p7_64 <<< 4);

  always_ff @(posedge clk) begin
    // signed quotient, wraps for the most negative dividend over -1
    if (ben[0] && div_out_valid) begin
      b0_p    <= $signed(div_side.neg ? (64'd0 - div_quo) : div_quo);
      b0_temp <= div_side.temp;
      b0_dz   <= div_side.dz;
    end
    if (ben[1] && bv[0]) begin
      b1_p    <= b0_p;
      b1_m    <= b0_ps * p9;
      b1_w2r  <= b0_p * p8;
      b1_temp <= b0_temp;
      b1_dz   <= b0_dz;
    end
    // low 64 bits of m * ps from 32-bit partial products
    if (ben[2] && bv[1]) begin
      b2_p    <= b1_p;
      b2_lo   <= {32'd0, b1_m[31:0]} * {32'd0, b1_ps[31:0]};
      b2_c1   <= b1_m[63:32] * b1_ps[31:0];
      b2_c2   <= b1_m[31:0] * b1_ps[63:32];
      b2_w2   <= b1_w2r >>> 19;
      b2_temp <= b1_temp;
      b2_dz   <= b1_dz;
    end
    if (ben[3] && bv[2]) begin
      b3_p    <= b2_p;
      b3_w1   <= $signed(b2_sum) >>> 25;
      b3_w2   <= b2_w2;
      b3_temp <= b2_temp;
      b3_dz   <= b2_dz;
    end
    // output register
    if (ben[4] && bv[3]) begin
      temperature_centi <= $signed(b3_temp);
      pressure_pa       <= b3_dz ? 32'd0 : b3_s[39:8];
      divisor_zero      <= b3_dz;
    end
  end

  assign out_valid = bv[BACK-1];

  // ---------------- assertions ----------------
  `BTPC_ASSERT_IMP(a_dz_zero_press, clk, rst, out_valid && divisor_zero, pressure_pa == 32'd0, "pressure not forced to zero on zero divisor")
  `BTPC_ASSERT_IMP(a_stall_only_full, clk, rst, !in_ready, out_valid && !out_ready && (&fv) && (&bv), "input stalled while pipeline has room")
  `BTPC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready && !in_ready, out_valid && !in_ready == !out_ready, "full pipeline did not hold")

endmodule
